// ===== src/arc_pkg.sv =====
// Shared types and codes for the ARP resolver cache.
// Depends on nothing; every file of the block takes names from here by scope.
package arc_pkg;

  localparam int unsigned TABLE_ENTRIES = 16;

  localparam int unsigned IP_W     = 32;
  localparam int unsigned MAC_W    = 48;
  localparam int unsigned OPCODE_W = 16;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned REPLY_W  = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 48;

  // input event kinds
  localparam logic [MODE_W-1:0] MODE_ARP_RX  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TIMER   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TX_IPV4 = 2'd2;

  // ARP opcodes as seen on the wire
  localparam logic [OPCODE_W-1:0] ARP_OP_REQUEST = 16'd1;
  localparam logic [OPCODE_W-1:0] ARP_OP_REPLY   = 16'd2;

  // opcode of the frame to send
  localparam logic [REPLY_W-1:0] SEND_OP_NONE    = 2'd0;
  localparam logic [REPLY_W-1:0] SEND_OP_REQUEST = 2'd1;
  localparam logic [REPLY_W-1:0] SEND_OP_REPLY   = 2'd2;

  // result actions
  localparam logic [ACTION_W-1:0] ACT_REPLY   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_BCAST   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_FORWARD = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_DROP    = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_FULL    = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_IP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GATEWAY_IP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC    = 2'd2;

  localparam logic [MAC_W-1:0] BCAST_MAC = {MAC_W{1'b1}};

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [REPLY_W-1:0]  reply_op;
    logic [MAC_W-1:0]    dest_mac;
    logic [IP_W-1:0]     dest_ip;
    logic [IP_W-1:0]     src_ip;
  } result_t;

endpackage

// ===== src/arp_resolver_cache_top.sv =====
// ARP responder with a learned IPv4-to-MAC neighbor table, top level.
// Depends on arc_pkg for codes, widths and the result word type.
//
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+------------------------------------------
//  in_     | in        | in_valid/in_stall | mode, op_code, sender_mac/ip, tgt_ip
//  out_    | out       | out_valid/out_stall | action, reply_op, dest_mac/ip, src_ip
//  cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_wdata (always ready)
//
// One word per cycle while in_stall is low: the table lookup (parallel compare
// over all entries), free-entry search and result select sit between the input
// ports and the output register, or the skid stage while a result waits there.
// Reset clears every table valid bit and the address registers; no sweep.
// A two-deep output (register plus skid) lets a word enter while a result
// waits; in_stall rises only once the skid stage holds a result.
module arp_resolver_cache_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input words
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [arc_pkg::MODE_W-1:0]           in_mode,
  input  logic [arc_pkg::OPCODE_W-1:0]         in_op_code,
  input  logic [arc_pkg::MAC_W-1:0]            in_sender_mac,
  input  logic [arc_pkg::IP_W-1:0]             in_sender_ip,
  input  logic [arc_pkg::IP_W-1:0]             in_tgt_ip,
  // result words
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [arc_pkg::ACTION_W-1:0]         out_action,
  output logic [arc_pkg::REPLY_W-1:0]          out_reply_op,
  output logic [arc_pkg::MAC_W-1:0]            out_dest_mac,
  output logic [arc_pkg::IP_W-1:0]             out_dest_ip,
  output logic [arc_pkg::IP_W-1:0]             out_src_ip,
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [arc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [arc_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int unsigned N = arc_pkg::TABLE_ENTRIES;

  // configuration
  logic [arc_pkg::IP_W-1:0] host_ip_r;
  logic [arc_pkg::IP_W-1:0] gw_ip_r;

  // neighbor table
  logic [N-1:0]              ent_vld_r;
  logic [arc_pkg::IP_W-1:0]  ent_ip_r  [N];
  logic [arc_pkg::MAC_W-1:0] ent_mac_r [N];

  // output register and skid stage
  logic             out_vld_r;
  logic             skid_vld_r;
  arc_pkg::result_t out_r;
  arc_pkg::result_t skid_r;

  logic             in_acc;
  logic             out_take;
  logic [N-1:0]     ip_hit;
  logic [N-1:0]     gw_hit;
  logic [N-1:0]     free_oh;
  logic [arc_pkg::MAC_W-1:0] gw_mac;
  logic             res_vld;
  logic             ins_en;
  arc_pkg::result_t res;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_vld_r;
  assign in_acc    = in_valid && !skid_vld_r;
  assign out_take  = out_vld_r && !out_stall;

  // The sender hardware address of outgoing frames is not part of any result
  // word, so an own_mac write is accepted and not kept.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      host_ip_r <= '0;
      gw_ip_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        arc_pkg::CFG_LOCAL_IP:   host_ip_r <= cfg_wdata[arc_pkg::IP_W-1:0];
        arc_pkg::CFG_GATEWAY_IP: gw_ip_r   <= cfg_wdata[arc_pkg::IP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Parallel compare; entries are never duplicated, so the hit vectors are
  // one-hot or empty and an AND-OR select is enough for the gateway MAC.
  always_comb begin
    gw_mac = '0;
    for (int i = 0; i < N; i++) begin
      ip_hit[i] = ent_vld_r[i] && (ent_ip_r[i] == in_sender_ip);
      gw_hit[i] = ent_vld_r[i] && (ent_ip_r[i] == gw_ip_r);
      gw_mac    = gw_mac | (ent_mac_r[i] & {arc_pkg::MAC_W{gw_hit[i]}});
    end
  end

  // lowest clear valid bit
  assign free_oh = ~ent_vld_r & (ent_vld_r + N'(1));

  always_comb begin
    res_vld = 1'b0;
    ins_en  = 1'b0;
    res     = '0;
    case (in_mode)
      arc_pkg::MODE_ARP_RX: begin
        if (in_tgt_ip == host_ip_r) begin
          if (in_op_code == arc_pkg::ARP_OP_REQUEST) begin
            res_vld      = 1'b1;
            res.action   = arc_pkg::ACT_REPLY;
            res.reply_op = arc_pkg::SEND_OP_REPLY;
            res.dest_mac = in_sender_mac;
            res.dest_ip  = in_sender_ip;
            res.src_ip   = in_tgt_ip;
          end else if (in_op_code == arc_pkg::ARP_OP_REPLY && !(|ip_hit)) begin
            if (&ent_vld_r) begin
              res_vld      = 1'b1;
              res.action   = arc_pkg::ACT_FULL;
              res.reply_op = arc_pkg::SEND_OP_NONE;
              res.dest_mac = in_sender_mac;
              res.dest_ip  = in_sender_ip;
            end else begin
              ins_en = 1'b1;
            end
          end
        end
      end
      arc_pkg::MODE_TIMER: begin
        if (!(|gw_hit)) begin
          res_vld      = 1'b1;
          res.action   = arc_pkg::ACT_BCAST;
          res.reply_op = arc_pkg::SEND_OP_REQUEST;
          res.dest_mac = arc_pkg::BCAST_MAC;
          res.dest_ip  = gw_ip_r;
          res.src_ip   = host_ip_r;
        end
      end
      arc_pkg::MODE_TX_IPV4: begin
        res_vld      = 1'b1;
        res.action   = (|gw_hit) ? arc_pkg::ACT_FORWARD : arc_pkg::ACT_DROP;
        res.reply_op = arc_pkg::SEND_OP_NONE;
        res.dest_mac = gw_mac;
        res.dest_ip  = gw_ip_r;
        res.src_ip   = host_ip_r;
      end
      default: begin
      end
    endcase
  end

  // learn into the lowest free entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
    end else if (in_acc && ins_en) begin
      ent_vld_r <= ent_vld_r | free_oh;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      if (in_acc && ins_en && free_oh[i]) begin
        ent_ip_r[i]  <= in_sender_ip;
        ent_mac_r[i] <= in_sender_mac;
      end
    end
  end

  // Output register with skid: a new result goes straight out when the output
  // is empty or draining, else it parks in the skid stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_take) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end
    end else if (in_acc && res_vld) begin
      if (!out_vld_r || out_take) begin
        out_vld_r <= 1'b1;
      end else begin
        skid_vld_r <= 1'b1;
      end
    end else if (out_take) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_take) begin
        out_r <= skid_r;
      end
    end else if (in_acc && res_vld) begin
      if (!out_vld_r || out_take) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign out_valid    = out_vld_r;
  assign out_action   = out_r.action;
  assign out_reply_op = out_r.reply_op;
  assign out_dest_mac = out_r.dest_mac;
  assign out_dest_ip  = out_r.dest_ip;
  assign out_src_ip   = out_r.src_ip;

endmodule

// ===== src/arc_checker.sv =====
// Port-level checks for the ARP resolver cache, bound to its top level.
// Depends on arc_pkg for action and opcode codes.
module arc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [arc_pkg::ACTION_W-1:0] out_action,
  input logic [arc_pkg::REPLY_W-1:0]  out_reply_op,
  input logic [arc_pkg::MAC_W-1:0]    out_dest_mac
);

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // a broadcast request always carries the request opcode and all-ones MAC
  a_bcast: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == arc_pkg::ACT_BCAST |->
      out_reply_op == arc_pkg::SEND_OP_REQUEST && out_dest_mac == arc_pkg::BCAST_MAC)
    else $error("broadcast request malformed");

  // only reply and request words carry an ARP opcode
  a_no_op: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action == arc_pkg::ACT_FORWARD || out_action == arc_pkg::ACT_DROP ||
                  out_action == arc_pkg::ACT_FULL) |->
      out_reply_op == arc_pkg::SEND_OP_NONE)
    else $error("opcode on a non-ARP result");

  // a drop never names a MAC
  a_drop_mac: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == arc_pkg::ACT_DROP |-> out_dest_mac == '0)
    else $error("drop result carries a MAC");

endmodule

bind arp_resolver_cache_top arc_checker u_arc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_action   (out_action),
  .out_reply_op (out_reply_op),
  .out_dest_mac (out_dest_mac)
);

// ===== tb/tb_arp_resolver_cache_top.sv =====
// Testbench for arp_resolver_cache_top: drives ARP, timer and outgoing-frame
// words with random gaps and stalls and checks every result word in order.
// Depends on arc_pkg and the block's RTL; self-contained otherwise.
`timescale 1ns / 1ps

import arc_pkg::*;

// Tracks the neighbor table and the address registers, predicts each action
// and compares it with the words the block emits.
class arp_scoreboard;
  logic [IP_W-1:0]  host_ip;
  logic [IP_W-1:0]  gw_ip;
  logic [MAC_W-1:0] own_mac;
  bit               nb_valid [TABLE_ENTRIES];
  logic [IP_W-1:0]  nb_ip    [TABLE_ENTRIES];
  logic [MAC_W-1:0] nb_mac   [TABLE_ENTRIES];
  result_t          expected_actions [$];
  int unsigned      errors;

  function new();
    host_ip = '0;
    gw_ip   = '0;
    own_mac = '0;
    errors  = 0;
    foreach (nb_valid[i]) nb_valid[i] = 1'b0;
  endfunction

  function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_LOCAL_IP:   host_ip = data[IP_W-1:0];
      CFG_GATEWAY_IP: gw_ip   = data[IP_W-1:0];
      CFG_OWN_MAC:    own_mac = data[MAC_W-1:0];
      default: ;
    endcase
  endfunction

  function int find_neighbor(logic [IP_W-1:0] ip);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (nb_valid[i] && nb_ip[i] == ip) return i;
    end
    return -1;
  endfunction

  function void queue_action(logic [ACTION_W-1:0] act, logic [REPLY_W-1:0] op,
                             logic [MAC_W-1:0] mac, logic [IP_W-1:0] dip,
                             logic [IP_W-1:0] sip);
    result_t w;
    w.action   = act;
    w.reply_op = op;
    w.dest_mac = mac;
    w.dest_ip  = dip;
    w.src_ip   = sip;
    expected_actions.push_back(w);
  endfunction

  function void note_event(logic [MODE_W-1:0] mode, logic [OPCODE_W-1:0] op,
                           logic [MAC_W-1:0] smac, logic [IP_W-1:0] sip,
                           logic [IP_W-1:0] tip);
    int slot;
    int free_idx;
    case (mode)
      MODE_ARP_RX: begin
        if (tip == host_ip) begin
          if (op == ARP_OP_REQUEST) begin
            queue_action(ACT_REPLY, SEND_OP_REPLY, smac, sip, tip);
          end else if (op == ARP_OP_REPLY && find_neighbor(sip) < 0) begin
            // learn into the lowest free entry, or report a full table
            free_idx = -1;
            for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
              if (!nb_valid[i]) free_idx = i;
            end
            if (free_idx < 0) begin
              queue_action(ACT_FULL, SEND_OP_NONE, smac, sip, '0);
            end else begin
              nb_valid[free_idx] = 1'b1;
              nb_ip[free_idx]    = sip;
              nb_mac[free_idx]   = smac;
            end
          end
        end
      end
      MODE_TIMER: begin
        if (find_neighbor(gw_ip) < 0)
          queue_action(ACT_BCAST, SEND_OP_REQUEST, BCAST_MAC, gw_ip, host_ip);
      end
      MODE_TX_IPV4: begin
        slot = find_neighbor(gw_ip);
        if (slot >= 0)
          queue_action(ACT_FORWARD, SEND_OP_NONE, nb_mac[slot], gw_ip, host_ip);
        else
          queue_action(ACT_DROP, SEND_OP_NONE, '0, gw_ip, host_ip);
      end
      default: ;
    endcase
  endfunction

  function bit pick_neighbor_ip(output logic [IP_W-1:0] ip);
    int n;
    int pick;
    n = 0;
    foreach (nb_valid[i]) if (nb_valid[i]) n++;
    if (n == 0) return 1'b0;
    pick = $urandom_range(n - 1);
    foreach (nb_valid[i]) begin
      if (nb_valid[i]) begin
        if (pick == 0) begin
          ip = nb_ip[i];
          return 1'b1;
        end
        pick--;
      end
    end
    return 1'b0;
  endfunction

  function void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  function void check_action(result_t got);
    result_t want;
    if (expected_actions.size() == 0) begin
      $error("result word with nothing expected: action %0d dest_ip 0x%0h",
             got.action, got.dest_ip);
      errors++;
      return;
    end
    want = expected_actions.pop_front();
    compare_field("action", want.action, got.action);
    compare_field("reply_op", want.reply_op, got.reply_op);
    compare_field("dest_mac", want.dest_mac, got.dest_mac);
    compare_field("dest_ip", want.dest_ip, got.dest_ip);
    compare_field("src_ip", want.src_ip, got.src_ip);
  endfunction

  function int pending();
    return expected_actions.size();
  endfunction
endclass

module tb_arp_resolver_cache_top;

  localparam int CLK_PERIOD    = 10;
  localparam int IDLE_PCT      = 35;
  localparam int PHASES        = 10;
  localparam int PHASE_WORDS   = 110;
  localparam int POOL_SIZE     = 24;
  localparam int HOLD_PHASE    = 3;
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_PHASE   = 6;
  localparam int SETTLE_CYCLES = 4;
  localparam int END_WAIT      = 2000;
  localparam int LIMIT_CYCLES  = 200000;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [MODE_W-1:0]     in_mode;
  logic [OPCODE_W-1:0]   in_op_code;
  logic [MAC_W-1:0]      in_sender_mac;
  logic [IP_W-1:0]       in_sender_ip;
  logic [IP_W-1:0]       in_tgt_ip;
  logic                  out_valid;
  logic                  out_stall;
  logic [ACTION_W-1:0]   out_action;
  logic [REPLY_W-1:0]    out_reply_op;
  logic [MAC_W-1:0]      out_dest_mac;
  logic [IP_W-1:0]       out_dest_ip;
  logic [IP_W-1:0]       out_src_ip;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  arp_scoreboard sb;
  result_t       seen_word;
  logic [IP_W-1:0] ip_pool [POOL_SIZE];
  int            phase_no = -1;
  bit            sender_idles = 1'b1;
  bit            receiver_idles = 1'b1;

  arp_resolver_cache_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_op_code    (in_op_code),
    .in_sender_mac (in_sender_mac),
    .in_sender_ip  (in_sender_ip),
    .in_tgt_ip     (in_tgt_ip),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_action    (out_action),
    .out_reply_op  (out_reply_op),
    .out_dest_mac  (out_dest_mac),
    .out_dest_ip   (out_dest_ip),
    .out_src_ip    (out_src_ip),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Results are checked before the same edge's input is noted: a result
  // always belongs to an earlier word.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        seen_word.action   = out_action;
        seen_word.reply_op = out_reply_op;
        seen_word.dest_mac = out_dest_mac;
        seen_word.dest_ip  = out_dest_ip;
        seen_word.src_ip   = out_src_ip;
        sb.check_action(seen_word);
      end
      if (cfg_valid && cfg_ready) sb.set_register(cfg_index, cfg_wdata);
      if (in_valid && !in_stall)
        sb.note_event(in_mode, in_op_code, in_sender_mac, in_sender_ip, in_tgt_ip);
    end
  end

  // Receiver: random stalls, one long hold-off, none in the quiet phase.
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && phase_no == HOLD_PHASE) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= receiver_idles && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL arp_resolver_cache_top");
    $finish;
  end

  function automatic logic [MAC_W-1:0] random_mac();
    logic [63:0] wide;
    int unsigned c;
    c = $urandom_range(9);
    wide = {$urandom, $urandom};
    if (c == 0) return '0;
    if (c == 1) return '1;
    return wide[MAC_W-1:0];
  endfunction

  // Hold each word until accepted; valid stays high into the next call.
  task automatic offer_word(input logic [MODE_W-1:0] mode, input logic [OPCODE_W-1:0] op,
                            input logic [MAC_W-1:0] smac, input logic [IP_W-1:0] sip,
                            input logic [IP_W-1:0] tip);
    while (sender_idles && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= mode;
    in_op_code    <= op;
    in_sender_mac <= smac;
    in_sender_ip  <= sip;
    in_tgt_ip     <= tip;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic apply_setting(input logic [IP_W-1:0] lip, input logic [IP_W-1:0] gip,
                               input logic [MAC_W-1:0] mac);
    logic [CFG_IDX_W-1:0]  regs [3];
    logic [CFG_DATA_W-1:0] values [3];
    int i;
    regs[0]   = CFG_LOCAL_IP;
    regs[1]   = CFG_GATEWAY_IP;
    regs[2]   = CFG_OWN_MAC;
    values[0] = CFG_DATA_W'(lip);
    values[1] = CFG_DATA_W'(gip);
    values[2] = mac;
    for (i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_wdata <= values[i];
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // Wait out every expected result, then let a no-result word finish.
  task automatic wait_drained();
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int p;
    int k;
    int r;
    int c;
    int w;
    bit known;
    logic [MODE_W-1:0]   mode;
    logic [OPCODE_W-1:0] op;
    logic [MAC_W-1:0]    smac;
    logic [IP_W-1:0]     sip;
    logic [IP_W-1:0]     tip;
    logic [IP_W-1:0]     set_local;
    logic [IP_W-1:0]     set_gw;
    logic [MAC_W-1:0]    set_mac;

    sb            = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_mode       = '0;
    in_op_code    = '0;
    in_sender_mac = '0;
    in_sender_ip  = '0;
    in_tgt_ip     = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    ip_pool[0]    = '0;
    ip_pool[1]    = '1;
    for (int i = 2; i < POOL_SIZE; i++) ip_pool[i] = $urandom;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: each event kind and corner, learning the gateway midway
    set_local = $urandom;
    set_gw    = ip_pool[2];
    apply_setting(set_local, set_gw, random_mac());
    offer_word(MODE_TIMER, '0, '0, '0, '0);
    offer_word(MODE_TX_IPV4, '1, '1, '1, '1);
    offer_word(MODE_ARP_RX, ARP_OP_REQUEST, '1, '1, set_local);
    offer_word(MODE_ARP_RX, ARP_OP_REQUEST, '0, '0, set_local);
    offer_word(MODE_ARP_RX, ARP_OP_REQUEST, random_mac(), $urandom, ~set_local);
    offer_word(MODE_ARP_RX, '0, random_mac(), $urandom, set_local);
    offer_word(MODE_ARP_RX, 16'd3, random_mac(), $urandom, set_local);
    offer_word(MODE_ARP_RX, '1, random_mac(), $urandom, set_local);
    offer_word(MODE_ARP_RX, ARP_OP_REPLY, '1, set_gw, ~set_local);
    offer_word(MODE_TX_IPV4, '0, '0, '0, '0);
    offer_word(MODE_ARP_RX, ARP_OP_REPLY, '1, set_gw, set_local);
    offer_word(MODE_ARP_RX, ARP_OP_REPLY, '0, set_gw, set_local);
    offer_word(MODE_TIMER, '0, '0, '0, '0);
    offer_word(MODE_TX_IPV4, '0, '0, '0, '0);
    offer_word(MODE_UNUSED, ARP_OP_REPLY, random_mac(), ip_pool[3], set_local);
    offer_word(MODE_ARP_RX, ARP_OP_REQUEST, random_mac(), ip_pool[3], set_local);
    offer_word(MODE_ARP_RX, ARP_OP_REPLY, random_mac(), ip_pool[3], set_local);
    offer_word(MODE_TX_IPV4, '0, '0, '0, '0);
    in_valid <= 1'b0;
    wait_drained();

    // random phases; the sender range of the pool widens so the table fills
    // gradually and later phases see a full table
    for (p = 0; p < PHASES; p++) begin
      phase_no       = p;
      sender_idles   = (p != QUIET_PHASE);
      receiver_idles = (p != QUIET_PHASE);
      k = (3 + 2 * p < POOL_SIZE) ? 3 + 2 * p : POOL_SIZE - 1;
      if (p == 0) begin
        set_local = '0;
        set_gw    = '0;
        set_mac   = '0;
      end else if (p == 1) begin
        set_local = '1;
        set_gw    = '1;
        set_mac   = '1;
      end else begin
        set_local = ($urandom_range(3) == 0) ? ip_pool[$urandom_range(k)] : $urandom;
        c = $urandom_range(99);
        known = 1'b0;
        if (c < 50) known = sb.pick_neighbor_ip(set_gw);
        if (!known) set_gw = (c < 80) ? ip_pool[$urandom_range(k)] : $urandom;
        set_mac = random_mac();
      end
      apply_setting(set_local, set_gw, set_mac);
      repeat (PHASE_WORDS) begin
        mode = MODE_W'($urandom_range(3));
        op   = OPCODE_W'($urandom);
        smac = random_mac();
        sip  = $urandom;
        tip  = $urandom;
        r    = $urandom_range(99);
        if (r < 55) begin
          mode = MODE_ARP_RX;
          if ($urandom_range(9) != 0) tip = set_local;
          c = $urandom_range(99);
          if (c < 45) op = ARP_OP_REQUEST;
          else if (c < 90) op = ARP_OP_REPLY;
          if ($urandom_range(9) < 7) sip = ip_pool[$urandom_range(k)];
        end else if (r < 70) begin
          mode = MODE_TIMER;
        end else if (r < 92) begin
          mode = MODE_TX_IPV4;
        end else if (r < 95) begin
          mode = MODE_UNUSED;
        end
        offer_word(mode, op, smac, sip, tip);
      end
      in_valid <= 1'b0;
      wait_drained();
    end

    for (w = 0; w < END_WAIT && sb.pending() != 0; w++) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.pending() != 0) begin
      $error("%0d expected result words never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0)
      $display("PASS arp_resolver_cache_top");
    else
      $display("FAIL arp_resolver_cache_top");
    $finish;
  end

endmodule
